### design/bha_pkg.sv
// Shared types and constants for the bounded histogram accumulator.
package bha_pkg;

  localparam int unsigned CNT_W    = 64;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned BIDX_W   = 8;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } bha_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_LOW  = 1'b0,
    REG_BIN_HIGH = 1'b1
  } bha_reg_t;

endpackage

### design/bha_bin_store.sv
// Bin count memory with a post-reset clearing sweep and write-to-read forwarding.
module bha_bin_store import bha_pkg::*; #(
  parameter int unsigned BINS  = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  cnt_t             wr_data,
  output cnt_t             cur_data,
  output logic             clr_busy
);

  cnt_t             mem [BINS];
  cnt_t             rd_data_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_addr_r;
  cnt_t             fwd_data_r;
  logic [IDX_W:0]   clr_cnt_r;
  logic [IDX_W:0]   clr_cnt_nxt;

  assign clr_busy    = clr_cnt_r < (IDX_W+1)'(BINS);
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // The last written entry always holds the newest count for its address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  assign cur_data = (fwd_valid_r && fwd_addr_r == rd_addr_r) ? fwd_data_r : rd_data_r;

endmodule

### design/bounded_histogram_accumulator_unit.sv
// Top level of the bounded histogram accumulator.
//
// Input channel (in_valid / in_stall): each item either adds a signed sample
// (opcode add) or reads one bin count (opcode read). Samples in
// [bin_low, bin_high] and below bin_low+BINS increment their bin; all others
// increment the overflow count. Every add bumps the sample count and the
// wrapping 64-bit sum. Result channel (out_valid / out_stall): exactly one
// result per item with the bin count and the three running totals.
// Throughput is one item per cycle while neither the clearing sweep nor the
// receiver stalls: the bin memory is read when an item is accepted and written
// back when the item leaves the update stage, and a forwarding register hands
// the newest count to a following item that hits the same bin. An accepted item
// waits in the update stage registers and then in the output register, which
// drives out_valid. After reset the bin memory is swept to zero, one entry per
// cycle, so in_stall stays high until the sweep is done; configuration writes
// are taken at any time. When the receiver stalls, the result holds in the output
// register, one more item may finish its memory read, and then in_stall rises.
module bounded_histogram_accumulator_unit import bha_pkg::*; #(
  parameter int unsigned BINS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic signed [31:0]   in_sample,
  input  logic [BIDX_W-1:0]    in_bin_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_bin_value,
  output logic [63:0]          out_overflow_total,
  output logic [63:0]          out_sample_total,
  output logic signed [63:0]   out_sample_sum,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (BINS > 1) ? $clog2(BINS) : 1;

  // Configuration registers.
  sample_t bin_low_r;
  sample_t bin_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_low_r  <= '0;
      bin_high_r <= SAMPLE_W'(255);
    end else if (cfg_wr_en) begin
      unique case (bha_reg_t'(cfg_index))
        REG_BIN_LOW:  bin_low_r  <= cfg_data;
        REG_BIN_HIGH: bin_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept stage: classify the item and pick the bin address.
  logic                     in_accept;
  bha_op_t                  in_op;
  logic [SAMPLE_W:0]        offset;
  logic                     in_range;
  logic                     add_hit;
  logic                     read_hit;
  logic [IDX_W+BIDX_W-1:0]  read_wide;
  logic [IDX_W-1:0]         in_addr;

  assign in_op     = bha_op_t'(in_opcode);
  assign offset    = {in_sample[SAMPLE_W-1], in_sample} - {bin_low_r[SAMPLE_W-1], bin_low_r};
  assign in_range  = ($signed(in_sample) >= $signed(bin_low_r)) &&
                     ($signed(in_sample) <= $signed(bin_high_r));
  assign add_hit   = in_range && (offset < (SAMPLE_W+1)'(BINS));
  assign read_wide = {{IDX_W{1'b0}}, in_bin_index};
  assign read_hit  = read_wide < (IDX_W+BIDX_W)'(BINS);
  assign in_addr   = (in_op == OP_READ) ? read_wide[IDX_W-1:0] : offset[IDX_W-1:0];

  // Update stage registers.
  logic             b_valid_r;
  bha_op_t          b_op_r;
  logic             b_hit_r;
  sample_t          b_sample_r;
  logic [IDX_W-1:0] b_addr_r;
  logic             b_move;
  logic             clr_busy;
  cnt_t             cur_data;
  cnt_t             inc_data;
  logic             wr_en;

  assign b_move    = b_valid_r && (!out_valid || !out_stall);
  assign in_stall  = clr_busy || (b_valid_r && !b_move);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_accept) begin
      b_valid_r <= 1'b1;
    end else if (b_move) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_op_r     <= in_op;
      b_hit_r    <= (in_op == OP_READ) ? read_hit : add_hit;
      b_sample_r <= in_sample;
      b_addr_r   <= in_addr;
    end
  end

  bha_bin_store #(
    .BINS  (BINS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (in_addr),
    .wr_en    (wr_en),
    .wr_addr  (b_addr_r),
    .wr_data  (inc_data),
    .cur_data (cur_data),
    .clr_busy (clr_busy)
  );

  assign inc_data = cur_data + 1'b1;
  assign wr_en    = b_move && (b_op_r == OP_ADD) && b_hit_r;

  // Running totals.
  cnt_t overflow_r;
  cnt_t overflow_nxt;
  cnt_t total_r;
  cnt_t total_nxt;
  cnt_t sum_r;
  cnt_t sum_nxt;
  cnt_t bin_val_nxt;

  always_comb begin
    overflow_nxt = overflow_r;
    total_nxt    = total_r;
    sum_nxt      = sum_r;
    bin_val_nxt  = '0;
    unique case (b_op_r)
      OP_ADD: begin
        total_nxt = total_r + 1'b1;
        sum_nxt   = sum_r + {{(CNT_W-SAMPLE_W){b_sample_r[SAMPLE_W-1]}}, b_sample_r};
        if (b_hit_r) begin
          bin_val_nxt = inc_data;
        end else begin
          overflow_nxt = overflow_r + 1'b1;
        end
      end
      OP_READ: begin
        if (b_hit_r) begin
          bin_val_nxt = cur_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overflow_r <= '0;
      total_r    <= '0;
      sum_r      <= '0;
    end else if (b_move) begin
      overflow_r <= overflow_nxt;
      total_r    <= total_nxt;
      sum_r      <= sum_nxt;
    end
  end

  // Output register; it holds its item while the receiver stalls.
  logic out_valid_r;
  cnt_t out_bin_r;
  cnt_t out_ovf_r;
  cnt_t out_tot_r;
  cnt_t out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_bin_r <= bin_val_nxt;
      out_ovf_r <= overflow_nxt;
      out_tot_r <= total_nxt;
      out_sum_r <= sum_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_value      = out_bin_r;
  assign out_overflow_total = out_ovf_r;
  assign out_sample_total   = out_tot_r;
  assign out_sample_sum     = out_sum_r;

  // No item may enter while the clearing sweep is still writing the memory.
  assert property (@(posedge clk) disable iff (!rst_n) clr_busy |-> in_stall)
    else $error("item accepted during the bin clearing sweep");

  // An accepted item always occupies the update stage on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> b_valid_r)
    else $error("accepted item lost before the update stage");

  // Each completed add bumps the sample count by exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_move && b_op_r == OP_ADD) |=> total_r == $past(total_r) + 1'b1)
    else $error("sample count did not advance on an add");

  // A read leaves every running total unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_move && b_op_r == OP_READ) |=> ($stable(overflow_r) && $stable(total_r) && $stable(sum_r)))
    else $error("read item changed a running total");

endmodule

### test/bounded_histogram_accumulator_unit_test.sv
// Self-checking testbench for the bounded histogram accumulator with random stimulus.
module bounded_histogram_accumulator_unit_test;
  import bha_pkg::*;

  localparam int BIN_COUNT   = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    bha_op_t            op;
    logic signed [31:0] sample;
    logic [BIDX_W-1:0]  bin;
  } hist_item_t;

  typedef struct {
    cnt_t               bin_value;
    cnt_t               overflow_total;
    cnt_t               sample_total;
    logic signed [63:0] sample_sum;
  } hist_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = 1'b0;
  logic signed [31:0]   in_sample = '0;
  logic [BIDX_W-1:0]    in_bin_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [63:0]          out_bin_value;
  logic [63:0]          out_overflow_total;
  logic [63:0]          out_sample_total;
  logic signed [63:0]   out_sample_sum;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Items waiting to be offered, and the results predicted for accepted items.
  hist_item_t   pending_items[$];
  hist_result_t predicted_results[$];

  // Shadow of the block's histogram state and range registers.
  cnt_t               bin_counts [BIN_COUNT] = '{default: '0};
  cnt_t               overflow_count = '0;
  cnt_t               sample_count = '0;
  logic signed [63:0] sample_accum = '0;
  logic signed [31:0] range_low = 32'sd0;
  logic signed [31:0] range_high = 32'sd255;

  int send_idle_pct = 31;
  int recv_idle_pct = 50;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  bounded_histogram_accumulator_unit #(
    .BINS(BIN_COUNT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sample         (in_sample),
    .in_bin_index      (in_bin_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bin_value     (out_bin_value),
    .out_overflow_total(out_overflow_total),
    .out_sample_total  (out_sample_total),
    .out_sample_sum    (out_sample_sum),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one item to the shadow state and returns the result it must produce.
  // A sample lands in a bin only if it is inside [low, high] and also within
  // the first BIN_COUNT values starting at low; everything else is an overflow.
  function automatic hist_result_t histogram_update(bha_op_t op, logic signed [31:0] smp,
                                                    logic [BIDX_W-1:0] bin);
    hist_result_t r;
    longint s;
    longint lo;
    longint hi;
    longint off;
    s   = smp;
    lo  = range_low;
    hi  = range_high;
    off = s - lo;
    r.bin_value = '0;
    if (op == OP_ADD) begin
      if (s >= lo && s <= hi && off < BIN_COUNT) begin
        bin_counts[off] = bin_counts[off] + 1;
        r.bin_value = bin_counts[off];
      end else begin
        overflow_count = overflow_count + 1;
      end
      sample_count = sample_count + 1;
      sample_accum = sample_accum + s;
    end else begin
      r.bin_value = bin_counts[bin];
    end
    r.overflow_total = overflow_count;
    r.sample_total   = sample_count;
    r.sample_sum     = sample_accum;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  // Sender: offers the next queued item unless it decides to idle this cycle.
  // The prediction is made at the edge where the item is accepted, so it always
  // sees the range registers the block used.
  always @(posedge clk) begin : drive_items
    hist_item_t nxt;
    logic       offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        predicted_results.push_back(histogram_update(bha_op_t'(in_opcode), in_sample,
                                                     in_bin_index));
        offer = 1'b0;
      end
      if (!offer && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_opcode    <= nxt.op;
        in_sample    <= nxt.sample;
        in_bin_index <= nxt.bin;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && (hold_left != 0 || $urandom_range(99) < recv_idle_pct);
  end

  // Receiver: each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    hist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no item outstanding", out_bin_value, '0);
      end else begin
        want = predicted_results.pop_front();
        if (out_bin_value !== want.bin_value)
          report_mismatch("bin_value", out_bin_value, want.bin_value);
        if (out_overflow_total !== want.overflow_total)
          report_mismatch("overflow_total", out_overflow_total, want.overflow_total);
        if (out_sample_total !== want.sample_total)
          report_mismatch("sample_total", out_sample_total, want.sample_total);
        if (out_sample_sum !== want.sample_sum)
          report_mismatch("sample_sum", out_sample_sum, want.sample_sum);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(input bha_op_t op, input logic signed [31:0] smp,
                            input logic [BIDX_W-1:0] bin);
    hist_item_t it;
    it.op     = op;
    it.sample = smp;
    it.bin    = bin;
    pending_items.push_back(it);
  endtask

  // Returns once every queued item is accepted and every result has arrived,
  // then lets further clock edges pass so the pipeline is certainly empty.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle, so the shadow copy can
  // be updated right away.
  task automatic write_reg(input bha_reg_t idx, input logic signed [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_BIN_LOW)
      range_low = value;
    else
      range_high = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_range(input logic signed [31:0] lo, input logic signed [31:0] hi);
    write_reg(REG_BIN_LOW, lo);
    write_reg(REG_BIN_HIGH, hi);
  endtask

  // Most samples fall just around the counted window so bins fill up and both
  // edges of the range are crossed; the rest are arbitrary or extreme values.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return range_low + $urandom_range(299) - 20;
    endcase
  endfunction

  task automatic queue_random(input int count);
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(99) < 65)
        queue_item(OP_ADD, pick_sample(), BIDX_W'($urandom_range(255)));
      else
        queue_item(OP_READ, $urandom(), BIDX_W'($urandom_range(255)));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    logic signed [31:0] lo;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Default range 0..255: both edges, overflow on either side, repeated hits
    // on one bin back to back, and a read of a bin never written.
    @(negedge clk);
    queue_item(OP_ADD, 32'sd0, 8'd0);
    queue_item(OP_ADD, 32'sd0, 8'd0);
    queue_item(OP_ADD, 32'sd255, 8'd0);
    queue_item(OP_ADD, 32'sd256, 8'd0);
    queue_item(OP_ADD, -32'sd1, 8'd0);
    queue_item(OP_ADD, 32'sh7fffffff, 8'd0);
    queue_item(OP_ADD, 32'sh80000000, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd255);
    queue_item(OP_READ, 32'sd0, 8'd77);
    wait_drained();

    // Full 32-bit range: wider than the bin store, so the tail overflows.
    set_range(32'sh80000000, 32'sh7fffffff);
    @(negedge clk);
    queue_item(OP_ADD, 32'sh80000000, 8'd0);
    queue_item(OP_ADD, 32'sh800000ff, 8'd0);
    queue_item(OP_ADD, 32'sh80000100, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd255);
    wait_drained();

    // High below low: every sample overflows, and old counts stay in place.
    set_range(32'sd10, 32'sd5);
    @(negedge clk);
    queue_item(OP_ADD, 32'sd7, 8'd0);
    queue_item(OP_ADD, 32'sd10, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd0);
    wait_drained();

    // Window ending at the largest sample value.
    set_range(32'sh7fffff9b, 32'sh7fffffff);
    @(negedge clk);
    queue_item(OP_ADD, 32'sh7fffffff, 8'd0);
    queue_item(OP_ADD, 32'sh7fffffff, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd100);
    wait_drained();

    // Narrow negative window; reading past its end returns the stored count.
    set_range(-32'sd50, -32'sd40);
    @(negedge clk);
    queue_item(OP_ADD, -32'sd45, 8'd0);
    queue_item(OP_ADD, -32'sd39, 8'd0);
    queue_item(OP_ADD, -32'sd50, 8'd0);
    queue_item(OP_READ, 32'sd0, 8'd200);
    queue_item(OP_READ, 32'sd0, 8'd5);
    wait_drained();

    // Random phase one: window of random width around a random base.
    lo = $urandom_range(2000);
    lo = lo - 1000;
    set_range(lo, lo + $urandom_range(400, 100));
    queue_random(320);
    wait_drained();

    // Random phase two: the idling roles swap.
    set_idling(50, 31);
    set_range(-32'sd128, 32'sd127);
    queue_random(320);
    wait_drained();

    // Random phase three: no idling, window at the top of the sample range, and
    // one long receiver hold-off so the block fills and pushes back.
    set_idling(0, 0);
    set_range(32'sh7fffff00, 32'sh7fffffff);
    queue_random(310);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
